// ===== rtl/mste_pkg.sv =====
// Package for the mismatch string token encoder: widths, token codes and result type.
package mste_pkg;

    localparam int RUN_WIDTH     = 16;
    localparam int VALUE_W       = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 24;

    localparam logic [2:0] NOT_BASE = 3'd5;

    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_SUBST = 2'd1,
        KIND_END   = 2'd2
    } token_kind_t;

    typedef struct packed {
        token_kind_t          kind;
        logic [VALUE_W-1:0]   value;
        logic                 err;
        logic                 var_seen;
        logic                 last;
    } token_t;

    // Map an upper-case letter to its base index, NOT_BASE if it is no base.
    function automatic logic [2:0] base_index(input logic [7:0] up);
        logic [2:0] idx;
        case (up)
            8'h41:   idx = 3'd0;   // A
            8'h43:   idx = 3'd1;   // C
            8'h47:   idx = 3'd2;   // G
            8'h54:   idx = 3'd3;   // T
            8'h4E:   idx = 3'd4;   // N
            default: idx = NOT_BASE;
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/mismatch_string_token_encoder.sv =====
// Top level of the mismatch string token encoder: character decode, token build, result queue.
// Each character's zero, one or two tokens enter the result queue at the edge that accepts it.
// Throughput: one character per cycle while s_tready is high; the four-entry result queue
//   drains one token per cycle while m_tready is high, so two-token characters set the pace.
// s_tready is high while the queue holds at most two tokens, so a full character always fits.
// Reset (rst_n low, asynchronous): run, pairing and variation state clear, queue empties.
module mismatch_string_token_encoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mste_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] text_char
    input  logic                               s_tlast,   // final_char
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mste_pkg::OUT_DATA_W-1:0]    m_tdata,   // [15:0] token_value, [16] pair_error,
                                                          // [17] has_variation, [23:18] zero
    output logic [1:0]                         m_tuser,   // [1:0] token_kind
    output logic                               m_tlast    // last_token
);
    import mste_pkg::*;

    localparam logic [RUN_WIDTH+3:0] RUN_MAX = {4'd0, {RUN_WIDTH{1'b1}}};

    // Character state
    logic [RUN_WIDTH-1:0] run_acc_reg, run_acc_next;
    logic                 run_pending_reg, run_pending_next;
    logic                 ref_pending_reg, ref_pending_next;
    logic [2:0]           ref_idx_reg, ref_idx_next;
    logic                 var_seen_reg, var_seen_next;

    // Result queue
    token_t               queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    logic                 in_xfer, out_xfer;
    logic [7:0]           ch;
    logic                 is_digit, is_upper, is_lower, is_letter;
    logic [7:0]           up;
    logic [2:0]           idx;
    logic [RUN_WIDTH+3:0] run_times10;
    logic [RUN_WIDTH-1:0] run_sat;
    logic [RUN_WIDTH-1:0] run_val;
    logic [RUN_WIDTH+VALUE_W-1:0] run_wide;
    logic [3:0]           code_sum;
    logic [1:0]           code;
    logic                 pair_bad;
    logic                 run_after, ref_after;
    logic                 emit_run, emit_pair, emit_endref, emit_plain;
    token_t               cand [4];
    logic [3:0]           cand_valid;
    token_t               tok0, tok1;
    logic [1:0]           n_tok;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Classify the character
    assign ch        = s_tdata;
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_upper  = (ch >= 8'h41) && (ch <= 8'h5A);
    assign is_lower  = (ch >= 8'h61) && (ch <= 8'h7A);
    assign is_letter = is_upper || is_lower;
    assign up        = is_lower ? (ch - 8'd32) : ch;
    assign idx       = base_index(up);

    // Run length: acc * 10 + digit, saturating
    assign run_times10 = ({4'd0, run_acc_reg} << 3) + ({4'd0, run_acc_reg} << 1)
                       + {{(RUN_WIDTH){1'b0}}, ch[3:0]};
    assign run_sat     = (run_times10 > RUN_MAX) ? {RUN_WIDTH{1'b1}}
                                                 : run_times10[RUN_WIDTH-1:0];
    assign run_val     = is_digit ? run_sat : run_acc_reg;
    assign run_wide    = {{VALUE_W{1'b0}}, run_val};

    // Substitution code: (alt - ref - 1) mod 5
    assign pair_bad = (ref_idx_reg >= NOT_BASE) || (idx >= NOT_BASE) || (ref_idx_reg == idx);
    assign code_sum = {1'b0, idx} + 4'd4 - {1'b0, ref_idx_reg};
    assign code     = (code_sum >= 4'd5) ? 2'(code_sum - 4'd5) : code_sum[1:0];

    // Pending flags once the character itself is taken
    assign run_after = is_digit ? 1'b1 : (is_letter ? 1'b0 : run_pending_reg);
    assign ref_after = is_letter ? !ref_pending_reg : ref_pending_reg;

    assign emit_run    = (is_letter && run_pending_reg) || (s_tlast && run_after);
    assign emit_pair   = is_letter && ref_pending_reg;
    assign emit_endref = s_tlast && ref_after;
    assign emit_plain  = s_tlast && !emit_run && !emit_pair && !emit_endref;

    assign var_seen_next = in_xfer ? ((is_letter && (idx != NOT_BASE)) || var_seen_reg)
                                   : var_seen_reg;

    // Candidate tokens in output order
    always_comb
    begin
        cand[0] = '{kind: KIND_RUN, value: run_wide[VALUE_W-1:0], err: 1'b0,
                    var_seen: 1'b0, last: 1'b0};
        cand[1] = '{kind: KIND_SUBST,
                    value: pair_bad ? '0 : {{(VALUE_W-2){1'b0}}, code},
                    err: pair_bad, var_seen: 1'b0, last: 1'b0};
        cand[2] = '{kind: KIND_END, value: '0, err: 1'b1, var_seen: 1'b0, last: 1'b0};
        cand[3] = '{kind: KIND_END, value: '0, err: 1'b0, var_seen: 1'b0, last: 1'b0};
        cand_valid = {emit_plain, emit_endref, emit_pair, emit_run};
    end

    // Pick the first two active tokens; mark the final one of the string
    always_comb
    begin
        tok0  = cand[3];
        tok1  = cand[3];
        n_tok = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_valid[i])
            begin
                if (n_tok == 2'd0)
                begin
                    tok0 = cand[i];
                end
                else
                begin
                    tok1 = cand[i];
                end
                n_tok = n_tok + 2'd1;
            end
        end
        tok0.var_seen = var_seen_next;
        tok1.var_seen = var_seen_next;
        tok0.last     = s_tlast && (n_tok == 2'd1);
        tok1.last     = s_tlast && (n_tok == 2'd2);
    end

    // Next character state; a final character clears everything
    always_comb
    begin
        run_acc_next     = run_acc_reg;
        run_pending_next = run_pending_reg;
        ref_pending_next = ref_pending_reg;
        ref_idx_next     = ref_idx_reg;
        if (in_xfer)
        begin
            if (s_tlast)
            begin
                run_acc_next     = '0;
                run_pending_next = 1'b0;
                ref_pending_next = 1'b0;
                ref_idx_next     = '0;
            end
            else if (is_digit)
            begin
                run_acc_next     = run_sat;
                run_pending_next = 1'b1;
            end
            else if (is_letter)
            begin
                run_acc_next     = '0;
                run_pending_next = 1'b0;
                ref_pending_next = !ref_pending_reg;
                ref_idx_next     = ref_pending_reg ? 3'd0 : idx;
            end
        end
    end

    // Queue pointers and fill level
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + QPTR_W'(out_xfer);
        wr_ptr_next = wr_ptr_reg + (in_xfer ? QPTR_W'(n_tok) : '0);
        count_next  = count_reg + (in_xfer ? QCNT_W'(n_tok) : '0) - QCNT_W'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_acc_reg     <= '0;
            run_pending_reg <= 1'b0;
            ref_pending_reg <= 1'b0;
            ref_idx_reg     <= '0;
            var_seen_reg    <= 1'b0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            run_acc_reg     <= run_acc_next;
            run_pending_reg <= run_pending_next;
            ref_pending_reg <= ref_pending_next;
            ref_idx_reg     <= ref_idx_next;
            var_seen_reg    <= (in_xfer && s_tlast) ? 1'b0 : var_seen_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            count_reg       <= count_next;
        end
    end

    // Token storage: write up to two entries per transaction
    always_ff @(posedge clk)
    begin
        if (in_xfer && (n_tok != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (in_xfer && (n_tok == 2'd2))
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= tok1;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(OUT_DATA_W-VALUE_W-2){1'b0}}, queue_reg[rd_ptr_reg].var_seen,
                       queue_reg[rd_ptr_reg].err, queue_reg[rd_ptr_reg].value};
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> (!run_pending_reg && !ref_pending_reg && !var_seen_reg))
        else $error("state not cleared after final character");

    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |-> (n_tok != 2'd0))
        else $error("final character produced no token");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> (count_reg + QCNT_W'(n_tok) <= QCNT_W'(QUEUE_DEPTH)))
        else $error("accepted character without queue room");

endmodule

// ===== tb/sv/mste_token_checker.sv =====
// Checker for the mismatch string token encoder: predicts the tokens of each character.
module mste_token_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mste_pkg::IN_DATA_W-1:0]  s_tdata,     // [7:0] text_char
    input  logic                            s_tlast,     // final_char
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mste_pkg::OUT_DATA_W-1:0] m_tdata,     // [15:0] token_value, [16] pair_error,
                                                         // [17] has_variation
    input  logic [1:0]                      m_tuser,     // [1:0] token_kind
    input  logic                            m_tlast,     // last_token
    output int                              mismatches,
    output int                              tokens_owed,
    output int                              tokens_seen
);
    import mste_pkg::*;

    localparam longint unsigned RUN_CEIL = (64'd1 << RUN_WIDTH) - 64'd1;

    // Encoder state as the checker sees it.
    bit [RUN_WIDTH-1:0] run_len;
    bit                 run_open;
    bit                 ref_open;
    bit [2:0]           ref_idx;
    bit                 var_seen;

    token_t             pending_tokens[$];

    function automatic logic [2:0] nucleotide(input logic [7:0] up);
        case (up)
            "A":     return 3'd0;
            "C":     return 3'd1;
            "G":     return 3'd2;
            "T":     return 3'd3;
            "N":     return 3'd4;
            default: return NOT_BASE;
        endcase
    endfunction

    function automatic token_t make_token(input token_kind_t kind,
                                          input logic [VALUE_W-1:0] value,
                                          input logic err);
        token_t t;
        t       = '0;
        t.kind  = kind;
        t.value = value;
        t.err   = err;
        return t;
    endfunction

    task automatic clear_string();
        run_len  = '0;
        run_open = 1'b0;
        ref_open = 1'b0;
        ref_idx  = '0;
        var_seen = 1'b0;
    endtask

    // Work out the tokens one character causes and queue them.
    task automatic encode_char(input logic [7:0] c, input logic fin);
        token_t          made[$];
        logic [7:0]      up;
        logic [2:0]      idx;
        longint unsigned grown;
        if (c >= "0" && c <= "9")
        begin
            grown   = 64'(run_len) * 64'd10 + 64'(c - 8'h30);
            run_len = (grown > RUN_CEIL) ? RUN_WIDTH'(RUN_CEIL) : RUN_WIDTH'(grown);
            run_open = 1'b1;
        end
        else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        begin
            up  = (c >= "a") ? c - 8'd32 : c;
            idx = nucleotide(up);
            if (run_open)
            begin
                made = {made, make_token(KIND_RUN, VALUE_W'(run_len), 1'b0)};
                run_len  = '0;
                run_open = 1'b0;
            end
            if (idx != NOT_BASE)
                var_seen = 1'b1;
            if (!ref_open)
            begin
                ref_open = 1'b1;
                ref_idx  = idx;
            end
            else
            begin
                ref_open = 1'b0;
                if (ref_idx >= NOT_BASE || idx >= NOT_BASE || ref_idx == idx)
                    made = {made, make_token(KIND_SUBST, '0, 1'b1)};
                else
                    made = {made, make_token(KIND_SUBST,
                        VALUE_W'((int'(idx) + 4 - int'(ref_idx)) % 5), 1'b0)};
                ref_idx = '0;
            end
        end

        if (fin)
        begin
            if (run_open)
                made = {made, make_token(KIND_RUN, VALUE_W'(run_len), 1'b0)};
            if (ref_open)
                made = {made, make_token(KIND_END, '0, 1'b1)};
            if (made.size() == 0)
                made = {made, make_token(KIND_END, '0, 1'b0)};
        end

        foreach (made[i])
        begin
            made[i].var_seen = var_seen;
            made[i].last     = fin && (i == made.size() - 1);
            pending_tokens   = {pending_tokens, made[i]};
        end

        if (fin)
            clear_string();
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: token %0d %s mismatch, expected %0d actual %0d",
                     $time, tokens_seen, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        token_t want;
        if (!rst_n)
        begin
            clear_string();
            pending_tokens.delete();
        end
        else
        begin
            // Compare first: a token leaving now is older than a character entering now.
            if (m_tvalid && m_tready)
            begin
                if (pending_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected token, expected none actual kind %0d value %0d",
                             $time, m_tuser, m_tdata[15:0]);
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    check_field("token_kind", want.kind, m_tuser);
                    check_field("token_value", want.value, m_tdata[15:0]);
                    check_field("pair_error", want.err, m_tdata[16]);
                    check_field("has_variation", want.var_seen, m_tdata[17]);
                    check_field("last_token", want.last, m_tlast);
                end
                tokens_seen++;
            end
            if (s_tvalid && s_tready)
                encode_char(s_tdata[7:0], s_tlast);
        end
        tokens_owed = pending_tokens.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the mismatch string token encoder: stimulus, flow control and verdict.
module tb;

    import mste_pkg::*;

    localparam int ITEM_TARGET = 1550;   // characters to send
    localparam int QUIET_FROM  = 1350;   // no idling after this many
    localparam int HOLD_AT     = 700;    // start the long output stall here
    localparam int LONG_HOLD   = 400;    // cycles of the long output stall
    localparam int LIMIT       = 2000;   // cycles without any transaction
    localparam int DRAIN       = 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    int  mismatches;
    int  tokens_owed;
    int  tokens_seen;

    int  chars_sent   = 0;
    int  strings_sent = 0;
    int  gap_odds     = 6;
    int  stall_cycles = 0;
    bit  idle_on      = 1'b1;
    bit  hold_request = 1'b0;
    bit  hold_issued  = 1'b0;

    logic [7:0] line_q[$];
    logic [7:0] base_chars[5] = '{"A", "C", "G", "T", "N"};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mismatch_string_token_encoder u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mste_token_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .tokens_owed (tokens_owed),
        .tokens_seen (tokens_seen)
    );

    // Watchdog: end the run with a failure when the transaction-free stall_cycles counter reaches LIMIT.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= LIMIT)
            begin
                $display("FAIL mismatch_string_token_encoder");
                $finish;
            end
        end
    end

    // Pick a base letter most of the time, any letter now and then, in either case.
    function automatic logic [7:0] pick_letter();
        logic [7:0] ch;
        if ($urandom_range(0, 9) == 0)
            ch = 8'("A" + $urandom_range(0, 25));
        else
            ch = base_chars[$urandom_range(0, 4)];
        if ($urandom_range(0, 1) == 1)
            ch = ch + 8'd32;
        return ch;
    endfunction

    function automatic logic [7:0] pick_noise();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_digits();
        int count;
        // Mostly short runs; now and then enough digits to saturate the run length.
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        repeat (count)
            line_q = {line_q, 8'("0" + $urandom_range(0, 9))};
    endtask

    // Build a mismatch string: runs and base pairs, sometimes a base left unpaired.
    task automatic compose_string();
        int segs;
        line_q.delete();
        segs = $urandom_range(0, 4);
        repeat (segs)
        begin
            if ($urandom_range(0, 3) != 0)
                add_digits();
            line_q = {line_q, pick_letter()};
            if ($urandom_range(0, 11) != 0)
                line_q = {line_q, pick_letter()};
        end
        if ($urandom_range(0, 1) == 1)
            add_digits();
        if (line_q.size() == 0)
            line_q = {line_q, pick_noise()};
    endtask

    // Offer one character and hold it until the transaction completes.
    task automatic offer_char(input logic [7:0] c, input logic fin);
        if (idle_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
        if (fin)
            strings_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            offer_char(text[i], i == text.len() - 1);
    endtask

    // Receiver: random stall bursts, ready stretches, and one long hold when asked.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: the textbook example, saturation, an ignored symbol inside a
        // run with a same-base pair and an unpaired letter, a string of only ignored
        // bytes at both ends of the byte range, and a non-base letter paired with a base.
        send_text("15AT20GC10");
        send_text("999999");
        send_text("3#4ggZ");
        offer_char(8'hFF, 1'b0);
        offer_char(8'h00, 1'b1);
        send_text("xc");

        // Random strings with noise bytes spliced in.
        while (chars_sent < ITEM_TARGET)
        begin
            compose_string();
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 6;
            foreach (line_q[i])
            begin
                if ($urandom_range(0, 11) == 0)
                    offer_char(pick_noise(), 1'b0);
                offer_char(line_q[i], i == line_q.size() - 1);
            end
            if (!hold_issued && chars_sent >= HOLD_AT)
            begin
                hold_issued  = 1'b1;
                hold_request = 1'b1;
            end
            if (chars_sent >= QUIET_FROM)
                idle_on = 1'b0;
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every predicted token, then let the bench settle before the verdict.
        @(posedge clk);
        wait (tokens_owed == 0);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d characters in %0d strings with noise, gaps and stalls,",
                 chars_sent, strings_sent);
        $display("including one %0d-cycle output hold; checked %0d tokens.",
                 LONG_HOLD, tokens_seen);
        if (mismatches == 0 && tokens_owed == 0)
            $display("PASS mismatch_string_token_encoder");
        else
            $display("FAIL mismatch_string_token_encoder");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mste_pkg.sv
rtl/mismatch_string_token_encoder.sv
tb/sv/mste_token_checker.sv
tb/sv/tb.sv
